### hdl/ttf_pkg.sv
// ttf_pkg: shared types for the triangle tangent frame block
// vertex and result words, and the request/response of the iterative div/sqrt unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ttf_pkg;

    // one input word: a vertex
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } vertex_t;

    // one output word: tangent frame of one vertex
    typedef struct packed {
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_z;
        logic signed [31:0] bitan_x;
        logic signed [31:0] bitan_y;
        logic signed [31:0] bitan_z;
        logic               degenerate;
        logic               last_of_triangle;
    } result_t;

    // request into the shared div/sqrt unit
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [34:0] den;
    } iter_req_t;

    // response from the shared div/sqrt unit
    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } iter_rsp_t;

endpackage

`default_nettype wire

### hdl/ttf_iter.sv
// ttf_iter: shared restoring divider / integer square root, one step per cycle
// unsigned 64-bit dividend by 35-bit divisor (64 steps), or 64-bit sqrt (32 steps)
// depends on ttf_pkg
`timescale 1ns / 1ps
`default_nettype none

module ttf_iter (
    input  logic               clk,
    input  logic               rst_n,
    input  ttf_pkg::iter_req_t req,
    output ttf_pkg::iter_rsp_t rsp
);

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);
    localparam logic [5:0] SQRT_LAST = 6'(SQRT_STEPS - 1);

    logic        busy_reg;
    logic        done_reg;
    logic        sqrt_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [37:0] rem_reg;
    logic [63:0] q_reg;
    logic [34:0] den_reg;

    logic [37:0] shifted;
    logic [37:0] trial;
    logic        ge;
    logic [37:0] rem_next;
    logic [63:0] q_next;
    logic [63:0] x_next;
    logic [5:0]  last;

    // one restoring step: bring down one bit (div) or a bit pair (sqrt)
    always_comb
    begin
        if (sqrt_reg)
        begin
            shifted = {rem_reg[35:0], x_reg[63:62]};
            trial   = {q_reg[35:0], 2'b01};
            x_next  = {x_reg[61:0], 2'b00};
            last    = SQRT_LAST;
        end
        else
        begin
            shifted = {rem_reg[36:0], x_reg[63]};
            trial   = 38'(den_reg);
            x_next  = {x_reg[62:0], 1'b0};
            last    = DIV_LAST;
        end
        ge       = (shifted >= trial);
        rem_next = ge ? (shifted - trial) : shifted;
        q_next   = {q_reg[62:0], ge};
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            sqrt_reg <= req.is_sqrt;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.num;
            rem_reg <= '0;
            q_reg   <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = q_reg;

endmodule

`default_nettype wire

### hdl/triangle_tangent_frame_top.sv
// The first two vertices of a triangle are only stored, with the input still ready. The third
// starts the computation, which uses up to twelve 64-step divisions and three 32-step square
// roots on the one div/sqrt unit; a zero UV determinant gives three degenerate words without
// them, and a zero len skips the three tangent divisions of that vertex. Input is not
// ready while a triangle runs. Reset clears phase, sequencer and output valid only.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_frame_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ttf_pkg::vertex_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ttf_pkg::result_t  out_data
);

    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_DELTA  = 6'd1;
    localparam logic [5:0] ST_DET0   = 6'd2;
    localparam logic [5:0] ST_DET1   = 6'd3;
    localparam logic [5:0] ST_DET2   = 6'd4;
    localparam logic [5:0] ST_DETCHK = 6'd5;
    localparam logic [5:0] ST_TN0    = 6'd6;
    localparam logic [5:0] ST_TN1    = 6'd7;
    localparam logic [5:0] ST_TN2    = 6'd8;
    localparam logic [5:0] ST_BN0    = 6'd9;
    localparam logic [5:0] ST_BN1    = 6'd10;
    localparam logic [5:0] ST_BN2    = 6'd11;
    localparam logic [5:0] ST_BN3    = 6'd12;
    localparam logic [5:0] ST_BN4    = 6'd13;
    localparam logic [5:0] ST_SHIFT  = 6'd14;
    localparam logic [5:0] ST_DOT    = 6'd15;
    localparam logic [5:0] ST_DOTE   = 6'd16;
    localparam logic [5:0] ST_PROJ   = 6'd17;
    localparam logic [5:0] ST_U0     = 6'd18;
    localparam logic [5:0] ST_U1     = 6'd19;
    localparam logic [5:0] ST_SQ     = 6'd20;
    localparam logic [5:0] ST_SQE    = 6'd21;
    localparam logic [5:0] ST_SQS    = 6'd22;
    localparam logic [5:0] ST_SQW    = 6'd23;
    localparam logic [5:0] ST_TQ0    = 6'd24;
    localparam logic [5:0] ST_TQ1    = 6'd25;
    localparam logic [5:0] ST_TQ2    = 6'd26;
    localparam logic [5:0] ST_CR0    = 6'd27;
    localparam logic [5:0] ST_CR1    = 6'd28;
    localparam logic [5:0] ST_CR2    = 6'd29;
    localparam logic [5:0] ST_CR3    = 6'd30;
    localparam logic [5:0] ST_CR4    = 6'd31;
    localparam logic [5:0] ST_EMIT   = 6'd32;
    localparam logic [5:0] ST_DEG    = 6'd33;

    localparam logic [1:0] PH_LAST = 2'd2;
    localparam logic [1:0] IX_LAST = 2'd2;

    // round to nearest by 2^14, ties away from zero
    function automatic logic signed [66:0] rnd14(input logic signed [66:0] x);
        logic [66:0] m;
        logic [66:0] q;
        m = x[66] ? 67'(-x) : 67'(x);
        q = (m + 67'd8192) >> 14;
        return x[66] ? -$signed(q) : $signed(q);
    endfunction

    // signed saturation of a rounded quotient magnitude
    function automatic logic signed [31:0] sat32(input logic [63:0] q, input logic neg);
        logic signed [31:0] r;
        if (neg)
            r = (q > 64'd2147483648) ? 32'sh8000_0000 : $signed(32'd0 - q[31:0]);
        else
            r = (q > 64'd2147483647) ? 32'sh7fff_ffff : $signed(q[31:0]);
        return r;
    endfunction

    // next and second-next component, for the cross product
    function automatic logic [1:0] rot1(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] rot2(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // control
    logic [1:0] phase_reg;
    logic [5:0] state_reg;
    logic [1:0] idx_reg;
    logic [1:0] vtx_reg;
    logic       out_valid_reg;

    // held vertices, slot 2 is the closing vertex
    logic signed [31:0] pos_reg [3][3];
    logic signed [15:0] uv_reg  [3][2];
    logic signed [15:0] nrm_reg [3][3];

    // triangle datapath
    logic signed [32:0] dp1_reg [3];
    logic signed [32:0] dp2_reg [3];
    logic signed [16:0] du1_reg;
    logic signed [16:0] dv1_reg;
    logic signed [16:0] du2_reg;
    logic signed [16:0] dv2_reg;
    logic signed [34:0] det_reg;
    logic               det_neg_reg;
    logic [34:0]        den_reg;
    logic [33:0]        half_reg;
    logic signed [65:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic [63:0]        num_reg;
    logic               neg_reg;
    logic [50:0]        tmag_reg [3];
    logic               tsgn_reg [3];
    logic signed [24:0] t_reg    [3];
    logic signed [29:0] proj_reg;
    logic signed [29:0] u_reg    [3];
    logic signed [15:0] tq_reg   [3];
    logic signed [31:0] bit_reg  [3];
    logic signed [31:0] diff_reg;
    ttf_pkg::result_t   out_reg;

    logic               accept;
    logic [1:0]         slot;
    logic               out_free;
    logic               load;
    logic [1:0]         n_sel;
    logic [1:0]         tq_sel;
    logic signed [15:0] n_cur;
    logic signed [15:0] tq_cur;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [34:0]        det_abs;
    logic signed [51:0] diff52;
    logic signed [51:0] tn_adj;
    logic [51:0]        mag52;
    logic [29:0]        u_abs;
    logic               big;
    logic [29:0]        len;
    logic [15:0]        q16;
    logic               cr_neg;

    ttf_pkg::iter_req_t iter_req;
    ttf_pkg::iter_rsp_t iter_rsp;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign slot     = (phase_reg == PH_LAST) ? 2'd2 : ((phase_reg == 2'd1) ? 2'd1 : 2'd0);
    assign out_free = !out_valid_reg || out_ready;
    assign load     = ((state_reg == ST_EMIT) || (state_reg == ST_DEG)) && out_free;

    // operand read ports
    assign n_sel  = (state_reg == ST_CR0) ? rot1(idx_reg) :
                    (state_reg == ST_CR1) ? rot2(idx_reg) : idx_reg;
    assign tq_sel = (state_reg == ST_CR0) ? rot2(idx_reg) : rot1(idx_reg);
    assign n_cur  = nrm_reg[vtx_reg][n_sel];
    assign tq_cur = tq_reg[tq_sel];

    // helpers on registered values
    assign det_abs = det_reg[34] ? 35'(-det_reg) : 35'(det_reg);
    assign diff52  = 52'(acc_reg - 67'(prod_reg));
    assign tn_adj  = det_neg_reg ? -diff52 : diff52;
    assign mag52   = diff52[51] ? 52'(-diff52) : 52'(diff52);
    assign u_abs   = u_reg[idx_reg][29] ? 30'(-u_reg[idx_reg]) : 30'(u_reg[idx_reg]);
    assign big     = |{tmag_reg[0][50:24], tmag_reg[1][50:24], tmag_reg[2][50:24]};
    assign len     = iter_rsp.res[29:0];
    assign q16     = iter_rsp.res[15:0];
    assign cr_neg  = acc_reg[66];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DET0:
            begin
                mul_a = 33'(du1_reg);
                mul_b = 33'(dv2_reg);
            end
            ST_DET1:
            begin
                mul_a = 33'(dv1_reg);
                mul_b = 33'(du2_reg);
            end
            ST_TN0:
            begin
                mul_a = dp1_reg[idx_reg];
                mul_b = 33'(dv2_reg);
            end
            ST_TN1:
            begin
                mul_a = dp2_reg[idx_reg];
                mul_b = 33'(dv1_reg);
            end
            ST_BN0:
            begin
                mul_a = dp2_reg[idx_reg];
                mul_b = 33'(du1_reg);
            end
            ST_BN1:
            begin
                mul_a = dp1_reg[idx_reg];
                mul_b = 33'(du2_reg);
            end
            ST_DOT:
            begin
                mul_a = 33'(n_cur);
                mul_b = 33'(t_reg[idx_reg]);
            end
            ST_U0:
            begin
                mul_a = 33'(n_cur);
                mul_b = 33'(proj_reg);
            end
            ST_SQ:
            begin
                mul_a = 33'(u_reg[idx_reg]);
                mul_b = 33'(u_reg[idx_reg]);
            end
            ST_CR0, ST_CR1:
            begin
                mul_a = 33'(n_cur);
                mul_b = 33'(tq_cur);
            end
            ST_CR3:
            begin
                mul_a = 33'(diff_reg);
                mul_b = 33'(bit_reg[idx_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // div/sqrt request
    assign iter_req.start   = (state_reg == ST_BN3) || (state_reg == ST_TQ1) ||
                              (state_reg == ST_SQS);
    assign iter_req.is_sqrt = (state_reg == ST_SQS);
    assign iter_req.num     = num_reg + 64'(half_reg);
    assign iter_req.den     = den_reg;

    ttf_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iter_req),
        .rsp   (iter_rsp)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            vtx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (slot == PH_LAST)
                        begin
                            phase_reg <= '0;
                            state_reg <= ST_DELTA;
                        end
                        else
                        begin
                            phase_reg <= slot + 2'd1;
                        end
                    end
                end
                ST_DELTA:  state_reg <= ST_DET0;
                ST_DET0:   state_reg <= ST_DET1;
                ST_DET1:   state_reg <= ST_DET2;
                ST_DET2:   state_reg <= ST_DETCHK;
                ST_DETCHK:
                begin
                    idx_reg   <= '0;
                    vtx_reg   <= '0;
                    state_reg <= (det_reg == '0) ? ST_DEG : ST_TN0;
                end
                ST_TN0:    state_reg <= ST_TN1;
                ST_TN1:    state_reg <= ST_TN2;
                ST_TN2:    state_reg <= ST_BN0;
                ST_BN0:    state_reg <= ST_BN1;
                ST_BN1:    state_reg <= ST_BN2;
                ST_BN2:    state_reg <= ST_BN3;
                ST_BN3:    state_reg <= ST_BN4;
                ST_BN4:
                begin
                    if (iter_rsp.done)
                    begin
                        if (idx_reg == IX_LAST)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_SHIFT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= ST_TN0;
                        end
                    end
                end
                ST_SHIFT:
                begin
                    if (!big)
                        state_reg <= ST_DOT;
                end
                ST_DOT:
                begin
                    if (idx_reg == IX_LAST)
                        state_reg <= ST_DOTE;
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                ST_DOTE:   state_reg <= ST_PROJ;
                ST_PROJ:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_U0;
                end
                ST_U0:     state_reg <= ST_U1;
                ST_U1:
                begin
                    if (idx_reg == IX_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_SQ;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_U0;
                    end
                end
                ST_SQ:
                begin
                    if (idx_reg == IX_LAST)
                        state_reg <= ST_SQE;
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                ST_SQE:    state_reg <= ST_SQS;
                ST_SQS:    state_reg <= ST_SQW;
                ST_SQW:
                begin
                    if (iter_rsp.done)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (len == '0) ? ST_CR0 : ST_TQ0;
                    end
                end
                ST_TQ0:    state_reg <= ST_TQ1;
                ST_TQ1:    state_reg <= ST_TQ2;
                ST_TQ2:
                begin
                    if (iter_rsp.done)
                    begin
                        if (idx_reg == IX_LAST)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_CR0;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= ST_TQ0;
                        end
                    end
                end
                ST_CR0:    state_reg <= ST_CR1;
                ST_CR1:    state_reg <= ST_CR2;
                ST_CR2:    state_reg <= ST_CR3;
                ST_CR3:    state_reg <= ST_CR4;
                ST_CR4:
                begin
                    if (idx_reg == IX_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_CR0;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        idx_reg <= '0;
                        if (vtx_reg == IX_LAST)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            vtx_reg   <= vtx_reg + 2'd1;
                            state_reg <= ST_DOT;
                        end
                    end
                end
                ST_DEG:
                begin
                    if (out_free)
                    begin
                        if (vtx_reg == IX_LAST)
                            state_reg <= ST_IDLE;
                        else
                            vtx_reg <= vtx_reg + 2'd1;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_reg[slot][0] <= in_data.pos_x;
                    pos_reg[slot][1] <= in_data.pos_y;
                    pos_reg[slot][2] <= in_data.pos_z;
                    uv_reg[slot][0]  <= in_data.tex_u;
                    uv_reg[slot][1]  <= in_data.tex_v;
                    nrm_reg[slot][0] <= in_data.norm_x;
                    nrm_reg[slot][1] <= in_data.norm_y;
                    nrm_reg[slot][2] <= in_data.norm_z;
                end
            end
            ST_DELTA:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dp1_reg[i] <= 33'(pos_reg[1][i]) - 33'(pos_reg[0][i]);
                    dp2_reg[i] <= 33'(pos_reg[2][i]) - 33'(pos_reg[0][i]);
                end
                du1_reg <= 17'(uv_reg[1][0]) - 17'(uv_reg[0][0]);
                dv1_reg <= 17'(uv_reg[1][1]) - 17'(uv_reg[0][1]);
                du2_reg <= 17'(uv_reg[2][0]) - 17'(uv_reg[0][0]);
                dv2_reg <= 17'(uv_reg[2][1]) - 17'(uv_reg[0][1]);
            end
            ST_DET1, ST_TN1, ST_BN1:
            begin
                acc_reg <= 67'(prod_reg);
            end
            ST_DET2:
            begin
                det_reg <= 35'(acc_reg - 67'(prod_reg));
            end
            ST_DETCHK:
            begin
                det_neg_reg <= det_reg[34];
                den_reg     <= det_abs;
                half_reg    <= 34'(det_abs >> 1);
            end
            ST_TN2:
            begin
                tsgn_reg[idx_reg] <= tn_adj[51];
                tmag_reg[idx_reg] <= tn_adj[51] ? 51'(-tn_adj) : 51'(tn_adj);
            end
            ST_BN2:
            begin
                neg_reg <= diff52[51] ^ det_neg_reg;
                num_reg <= 64'(mag52) << 12;
            end
            ST_BN4:
            begin
                if (iter_rsp.done)
                    bit_reg[idx_reg] <= sat32(iter_rsp.res, neg_reg);
            end
            ST_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (big)
                        tmag_reg[i] <= tmag_reg[i] >> 1;
                    else
                        t_reg[i] <= tsgn_reg[i] ? -$signed({1'b0, tmag_reg[i][23:0]})
                                                :  $signed({1'b0, tmag_reg[i][23:0]});
                end
            end
            ST_DOT, ST_SQ:
            begin
                acc_reg <= (idx_reg == '0) ? '0 : acc_reg + 67'(prod_reg);
            end
            ST_DOTE:
            begin
                acc_reg <= acc_reg + 67'(prod_reg);
            end
            ST_PROJ:
            begin
                proj_reg <= 30'(rnd14(acc_reg));
            end
            ST_U1:
            begin
                u_reg[idx_reg] <= 30'(67'(t_reg[idx_reg]) - rnd14(67'(prod_reg)));
            end
            ST_SQE:
            begin
                num_reg  <= 64'(acc_reg + 67'(prod_reg));
                half_reg <= '0;
            end
            ST_SQW:
            begin
                if (iter_rsp.done)
                begin
                    den_reg  <= 35'(len);
                    half_reg <= 34'(len >> 1);
                    if (len == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                            tq_reg[i] <= '0;
                    end
                end
            end
            ST_TQ0:
            begin
                neg_reg <= u_reg[idx_reg][29];
                num_reg <= 64'(u_abs) << 14;
            end
            ST_TQ2:
            begin
                if (iter_rsp.done)
                    tq_reg[idx_reg] <= neg_reg ? -$signed(q16) : $signed(q16);
            end
            ST_CR1:
            begin
                diff_reg <= 32'(prod_reg);
            end
            ST_CR2:
            begin
                diff_reg <= diff_reg - 32'(prod_reg);
            end
            ST_CR4:
            begin
                acc_reg <= ((idx_reg == '0) ? 67'sd0 : acc_reg) + 67'(prod_reg);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_reg.tan_x            <= cr_neg ? -tq_reg[0] : tq_reg[0];
                    out_reg.tan_y            <= cr_neg ? -tq_reg[1] : tq_reg[1];
                    out_reg.tan_z            <= cr_neg ? -tq_reg[2] : tq_reg[2];
                    out_reg.bitan_x          <= bit_reg[0];
                    out_reg.bitan_y          <= bit_reg[1];
                    out_reg.bitan_z          <= bit_reg[2];
                    out_reg.degenerate       <= 1'b0;
                    out_reg.last_of_triangle <= (vtx_reg == IX_LAST);
                end
            end
            ST_DEG:
            begin
                if (out_free)
                begin
                    out_reg.tan_x            <= '0;
                    out_reg.tan_y            <= '0;
                    out_reg.tan_z            <= '0;
                    out_reg.bitan_x          <= '0;
                    out_reg.bitan_y          <= '0;
                    out_reg.bitan_z          <= '0;
                    out_reg.degenerate       <= 1'b1;
                    out_reg.last_of_triangle <= (vtx_reg == IX_LAST);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### verif/tb_triangle_tangent_frame_top.sv
// tb_triangle_tangent_frame_top: self-checking bench for the triangle tangent frame block
// drives vertex words, predicts the three tangent-frame words per triangle and checks them
// depends on ttf_pkg and triangle_tangent_frame_top
`timescale 1ns / 1ps

module tb_triangle_tangent_frame_top;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    ttf_pkg::vertex_t in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    ttf_pkg::result_t out_data;

    triangle_tangent_frame_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #2 clk = ~clk;

    // predictor state: position within the triangle and the held vertices
    int unsigned      corner_idx;
    ttf_pkg::vertex_t held_vtx [2];
    ttf_pkg::result_t frame_q [$];
    int unsigned      err_count;
    int unsigned      vtx_sent;
    int unsigned      frames_seen;
    int unsigned      degen_seen;
    longint unsigned  cyc;

    // append one expected word at the tail of the queue
    function automatic void queue_frame(ttf_pkg::result_t r);
        frame_q = {frame_q, r};
    endfunction

    // round(n/d), ties away from zero
    function automatic longint rnd_div(longint n, longint d);
        longint unsigned an, ad, q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (an + ad / 2) / ad;
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // tangent frame of a finished triangle, queued in vertex order
    task automatic predict_frames(ttf_pkg::vertex_t v2);
        longint p [3][3];
        longint nr [3][3];
        longint tu [3];
        longint tv [3];
        longint dp1 [3];
        longint dp2 [3];
        longint bt [3];
        longint t [3];
        longint u [3];
        longint tq [3];
        longint du1, dv1, du2, dv2, det, bn, tn, dot, proj, cr;
        longint unsigned mx, m, ss, len;
        int k;
        ttf_pkg::vertex_t vv [3];
        ttf_pkg::result_t r;
        vv[0] = held_vtx[0];
        vv[1] = held_vtx[1];
        vv[2] = v2;
        for (int v = 0; v < 3; v++)
        begin
            p[v][0] = longint'(vv[v].pos_x);
            p[v][1] = longint'(vv[v].pos_y);
            p[v][2] = longint'(vv[v].pos_z);
            nr[v][0] = longint'(vv[v].norm_x);
            nr[v][1] = longint'(vv[v].norm_y);
            nr[v][2] = longint'(vv[v].norm_z);
            tu[v] = longint'(vv[v].tex_u);
            tv[v] = longint'(vv[v].tex_v);
        end
        for (int i = 0; i < 3; i++)
        begin
            dp1[i] = p[1][i] - p[0][i];
            dp2[i] = p[2][i] - p[0][i];
        end
        du1 = tu[1] - tu[0]; dv1 = tv[1] - tv[0];
        du2 = tu[2] - tu[0]; dv2 = tv[2] - tv[0];
        det = du1 * dv2 - dv1 * du2;
        if (det == 0)
        begin
            degen_seen++;
            for (int v = 0; v < 3; v++)
            begin
                r = '0;
                r.degenerate = 1'b1;
                r.last_of_triangle = (v == 2);
                queue_frame(r);
            end
            return;
        end
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            bn = dp2[i] * du1 - dp1[i] * du2;
            tn = dp1[i] * dv2 - dp2[i] * dv1;
            bt[i] = clamp32(rnd_div(bn * 4096, det));
            if (det < 0) tn = -tn;
            t[i] = tn;
            m = (tn < 0) ? -tn : tn;
            if (m > mx) mx = m;
        end
        k = 0;
        while ((mx >> k) >= (64'd1 << 24)) k++;
        for (int i = 0; i < 3; i++)
        begin
            m = ((t[i] < 0) ? -t[i] : t[i]) >> k;
            t[i] = (t[i] < 0) ? -longint'(m) : longint'(m);
        end
        for (int v = 0; v < 3; v++)
        begin
            dot = nr[v][0] * t[0] + nr[v][1] * t[1] + nr[v][2] * t[2];
            proj = rnd_div(dot, 16384);
            ss = 0;
            for (int i = 0; i < 3; i++)
            begin
                u[i] = t[i] - rnd_div(nr[v][i] * proj, 16384);
                ss += longint'(u[i] * u[i]);
            end
            len = int_sqrt(ss);
            for (int i = 0; i < 3; i++)
                tq[i] = (len == 0) ? 0 : rnd_div(u[i] * 16384, longint'(len));
            cr = (nr[v][1] * tq[2] - nr[v][2] * tq[1]) * bt[0]
               + (nr[v][2] * tq[0] - nr[v][0] * tq[2]) * bt[1]
               + (nr[v][0] * tq[1] - nr[v][1] * tq[0]) * bt[2];
            if (cr < 0)
                for (int i = 0; i < 3; i++) tq[i] = -tq[i];
            r.tan_x = 16'(tq[0]); r.tan_y = 16'(tq[1]); r.tan_z = 16'(tq[2]);
            r.bitan_x = 32'(bt[0]); r.bitan_y = 32'(bt[1]); r.bitan_z = 32'(bt[2]);
            r.degenerate = 1'b0;
            r.last_of_triangle = (v == 2);
            queue_frame(r);
        end
    endtask

    // sender burst pattern: a random gap before some words
    int unsigned burst_left;

    // valid stays high after a word is taken until the next word or an idle stretch
    task automatic send_vertex(ttf_pkg::vertex_t w);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // accepted at this edge
        if (corner_idx == 2)
        begin
            predict_frames(w);
            corner_idx = 0;
        end
        else
        begin
            held_vtx[corner_idx] = w;
            corner_idx++;
        end
        vtx_sent++;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            frames_seen++;
            if (frame_q.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, out_data);
                err_count++;
            end
            else
            begin
                ttf_pkg::result_t e;
                e = frame_q.pop_front();
                if (out_data !== e)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
                    $display("  tan exp %0d %0d %0d act %0d %0d %0d", e.tan_x, e.tan_y,
                             e.tan_z, out_data.tan_x, out_data.tan_y, out_data.tan_z);
                    $display("  bitan exp %0d %0d %0d act %0d %0d %0d deg/last exp %b%b act %b%b",
                             e.bitan_x, e.bitan_y, e.bitan_z, out_data.bitan_x,
                             out_data.bitan_y, out_data.bitan_z, e.degenerate,
                             e.last_of_triangle, out_data.degenerate,
                             out_data.last_of_triangle);
                    err_count++;
                end
            end
        end
    end

    // receiver stall pattern: phases of always-ready and random stalls
    int unsigned stall_mode;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // watchdog
    always @(posedge clk)
    begin
        cyc++;
        if (cyc > 64'd2000000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic ttf_pkg::vertex_t rand_vertex();
        ttf_pkg::vertex_t w;
        w.pos_x = $urandom; w.pos_y = $urandom; w.pos_z = $urandom;
        w.tex_u = 16'($urandom); w.tex_v = 16'($urandom);
        w.norm_x = 16'($urandom_range(0, 32768) - 16384);
        w.norm_y = 16'($urandom_range(0, 32768) - 16384);
        w.norm_z = 16'($urandom_range(0, 32768) - 16384);
        return w;
    endfunction

    // plausible vertex: small positions, unit normal in three of four cases
    function automatic ttf_pkg::vertex_t mild_vertex();
        ttf_pkg::vertex_t w;
        w = rand_vertex();
        w.pos_x = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
        w.pos_y = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
        w.pos_z = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
        w.tex_u = 16'($signed($urandom_range(0, 8192)) - 4096);
        w.tex_v = 16'($signed($urandom_range(0, 8192)) - 4096);
        case ($urandom_range(0, 3))
            0: begin w.norm_x = 16'sd16384; w.norm_y = 16'sd0; w.norm_z = 16'sd0; end
            1: begin w.norm_x = 16'sd0; w.norm_y = -16'sd16384; w.norm_z = 16'sd0; end
            2: begin w.norm_x = 16'sd9459; w.norm_y = 16'sd9459; w.norm_z = -16'sd9459; end
            default: ;
        endcase
        return w;
    endfunction

    function automatic ttf_pkg::vertex_t make_vtx(int px, int py, int pz, int tu, int tv,
                                                  int nx, int ny, int nz);
        ttf_pkg::vertex_t w;
        w.pos_x = px; w.pos_y = py; w.pos_z = pz;
        w.tex_u = 16'(tu); w.tex_v = 16'(tv);
        w.norm_x = 16'(nx); w.norm_y = 16'(ny); w.norm_z = 16'(nz);
        return w;
    endfunction

    // idle the input and wait until every expected word has come
    task automatic drain();
        in_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    // directed: simple frame, zero determinant, tangent along normal, saturation, extremes
    task automatic test_directed();
        send_vertex(make_vtx(0, 0, 0, 0, 0, 0, 0, 16384));
        send_vertex(make_vtx(65536, 0, 0, 4096, 0, 0, 0, 16384));
        send_vertex(make_vtx(0, 65536, 0, 0, 4096, 0, 0, -16384));
        // zero determinant: collinear uv
        send_vertex(make_vtx(5, 6, 7, 100, 100, 16384, 0, 0));
        send_vertex(make_vtx(9, 1, 3, 200, 200, 0, 16384, 0));
        send_vertex(make_vtx(4, 8, 2, 300, 300, 0, 0, 16384));
        // tangent along the normal x: tan fields zero
        send_vertex(make_vtx(0, 0, 0, 0, 0, 16384, 0, 0));
        send_vertex(make_vtx(65536, 0, 0, 4096, 0, 16384, 0, 0));
        send_vertex(make_vtx(0, 65536, 0, 0, 4096, 16384, 0, 0));
        // huge bitangent saturates, extreme fields
        send_vertex(make_vtx(-2147483648, -2147483648, 2147483647, 0, 0,
                             -16384, -16384, 16384));
        send_vertex(make_vtx(2147483647, 2147483647, -2147483648, 1, 0,
                             16384, 16384, -16384));
        send_vertex(make_vtx(-2147483648, 2147483647, 0, 0, 1, 0, 0, 0));
        send_vertex(make_vtx(0, 0, 0, -32768, -32768, 0, 0, 0));
        send_vertex(make_vtx(-1, -1, -1, 32767, -32768, -1, -1, -1));
        send_vertex(make_vtx(2147483647, 0, -2147483648, -32768, 32767, 1, 2, 3));
        drain();
    endtask

    task automatic test_triangles(int unsigned n_vtx);
        for (int unsigned i = 0; i < n_vtx; i++)
        begin
            if ($urandom_range(0, 3) == 0) send_vertex(rand_vertex());
            else send_vertex(mild_vertex());
            // hold off until the output side is empty once mid-run
            if (i == n_vtx / 2) drain();
        end
    endtask

    initial
    begin
        corner_idx = 0;
        err_count = 0;
        vtx_sent = 0;
        frames_seen = 0;
        degen_seen = 0;
        burst_left = 0;
        stall_mode = 0;
        cyc = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_triangles(414);
        drain();
        repeat (1100) @(negedge clk);
        $display("ran %0d vertices, checked %0d frame words (%0d degenerate triangles)",
                 vtx_sent, frames_seen, degen_seen);
        if (err_count == 0 && frame_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
